@@ src/pat_pkg.sv @@
package pat_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int TRIG_FRAC = 16;

	localparam int COORD_W = 32;
	localparam int CMD_W = 3;
	localparam int ANGLE_IN_W = 16;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SINE_W = TRIG_FRAC + 1;
	localparam int TRIG_W = TRIG_FRAC + 2;
	localparam int TRIG_ONE = 1 << TRIG_FRAC;

	localparam int QUARTER_W = ANGLE_BITS - 2;
	localparam int QUARTER = 1 << QUARTER_W;
	localparam int ANGLE_DROP = (ANGLE_BITS <= ANGLE_IN_W) ? ANGLE_IN_W - ANGLE_BITS : 0;
	localparam int ANGLE_PAD = (ANGLE_BITS > ANGLE_IN_W) ? ANGLE_BITS - ANGLE_IN_W : 0;
	localparam int ANGLE_WIDE_W = ANGLE_IN_W + ANGLE_PAD;

	localparam int IN_TDATA_W = ((4 * COORD_W + ANGLE_IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((3 * COORD_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// Rounded-up reciprocals of the Taylor divisors (2n)(2n+1), n = 1 to 12.
	localparam int RECIP_SHIFT = 48;
	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
	localparam logic [63:0] RECIP_TERM1 = (RECIP_ONE + 64'd5) / 64'd6;
	localparam logic [63:0] RECIP_TERM2 = (RECIP_ONE + 64'd19) / 64'd20;
	localparam logic [63:0] RECIP_TERM3 = (RECIP_ONE + 64'd41) / 64'd42;
	localparam logic [63:0] RECIP_TERM4 = (RECIP_ONE + 64'd71) / 64'd72;
	localparam logic [63:0] RECIP_TERM5 = (RECIP_ONE + 64'd109) / 64'd110;
	localparam logic [63:0] RECIP_TERM6 = (RECIP_ONE + 64'd155) / 64'd156;
	localparam logic [63:0] RECIP_TERM7 = (RECIP_ONE + 64'd209) / 64'd210;
	localparam logic [63:0] RECIP_TERM8 = (RECIP_ONE + 64'd271) / 64'd272;
	localparam logic [63:0] RECIP_TERM9 = (RECIP_ONE + 64'd341) / 64'd342;
	localparam logic [63:0] RECIP_TERM10 = (RECIP_ONE + 64'd419) / 64'd420;
	localparam logic [63:0] RECIP_TERM11 = (RECIP_ONE + 64'd505) / 64'd506;
	localparam logic [63:0] RECIP_TERM12 = (RECIP_ONE + 64'd599) / 64'd600;

	localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_TRANSLATE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SCALE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ROT_X = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROT_Y = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ROT_Z = 3'd5;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic [QUARTER_W-1:0] quarter_idx_t;
	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic [ANGLE_WIDE_W-1:0] angle_wide_t;

	localparam coord_t COORD_MAX = 32'sh7FFFFFFF;
	localparam coord_t COORD_MIN = 32'sh80000000;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_TRANSLATE,
		OP_SCALE,
		OP_ROT_X,
		OP_ROT_Y,
		OP_ROT_Z,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t    op;
		coord_t vec_x;
		coord_t vec_y;
		coord_t vec_z;
		coord_t factor;
		trig_t  sin_v;
		trig_t  cos_v;
	} item_t;

	typedef struct packed {
		logic   clip;
		coord_t value;
	} sat_res_t;

	function automatic logic [63:0] taylor_recip(input int n);
		case (n)
			1:       return RECIP_TERM1;
			2:       return RECIP_TERM2;
			3:       return RECIP_TERM3;
			4:       return RECIP_TERM4;
			5:       return RECIP_TERM5;
			6:       return RECIP_TERM6;
			7:       return RECIP_TERM7;
			8:       return RECIP_TERM8;
			9:       return RECIP_TERM9;
			10:      return RECIP_TERM10;
			11:      return RECIP_TERM11;
			12:      return RECIP_TERM12;
			default: return '0;
		endcase
	endfunction

	// Quarter-wave sine by a Taylor series in Q30, rounded to the trig format.
	// Gives one table entry; the tables are filled from it once at start-up.
	// Each term is divided by multiplying with a rounded-up reciprocal. The
	// dividend stays below 2^33, well inside the range where that is exact.
	function automatic logic [SINE_W-1:0] sine_entry(input int k);
		logic [63:0] step;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic [127:0] scaled;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		step = HALF_PI_Q62 >> QUARTER_W;
		t = (step * 64'(k) + (64'd1 << 31)) >> 32;
		t2 = (t * t + (64'd1 << 29)) >> 30;
		term = t;
		sum = signed'(t);
		for (int n = 1; n <= 12; n++) begin
			term = (term * t2 + (64'd1 << 29)) >> 30;
			scaled = 128'(term) * 128'(taylor_recip(n));
			term = scaled[RECIP_SHIFT +: 64];
			if (n[0]) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		r = (sum + (64'sd1 << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
		if (r > 64'(TRIG_ONE)) begin
			r = 64'(TRIG_ONE);
		end
		return r[SINE_W-1:0];
	endfunction

	// Round half up after the binary point, add the pivot back, then clip.
	function automatic sat_res_t round_sat(input prod_t v, input coord_t pivot,
			input logic is_scale);
		prod_t q;
		prod_t t;
		sat_res_t r;
		if (is_scale) begin
			q = v >>> FRAC_BITS;
			t = q + prod_t'(pivot) + prod_t'(v[FRAC_BITS-1]);
		end else begin
			q = v >>> TRIG_FRAC;
			t = q + prod_t'(pivot) + prod_t'(v[TRIG_FRAC-1]);
		end
		if (t > prod_t'(COORD_MAX)) begin
			r.clip = 1'b1;
			r.value = COORD_MAX;
		end else if (t < prod_t'(COORD_MIN)) begin
			r.clip = 1'b1;
			r.value = COORD_MIN;
		end else begin
			r.clip = 1'b0;
			r.value = t[COORD_W-1:0];
		end
		return r;
	endfunction

	function automatic sat_res_t sat_add(input coord_t a, input coord_t b);
		diff_t s;
		sat_res_t r;
		s = diff_t'(a) + diff_t'(b);
		if (s[DIFF_W-1] != s[DIFF_W-2]) begin
			r.clip = 1'b1;
			r.value = s[DIFF_W-1] ? COORD_MIN : COORD_MAX;
		end else begin
			r.clip = 1'b0;
			r.value = s[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ src/pat_sin_rom.sv @@
module pat_sin_rom (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pat_pkg::QUARTER_W-1:0] addr,
	output logic [pat_pkg::SINE_W-1:0]    data
);

	logic [pat_pkg::SINE_W-1:0] sine_q [pat_pkg::QUARTER];
	logic [pat_pkg::SINE_W-1:0] data_q;

	// The table is filled once at start-up and is never written in operation.
	initial begin
		for (int k = 0; k < pat_pkg::QUARTER; k++) begin
			sine_q[k] = pat_pkg::sine_entry(k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= sine_q[addr];
		end
	end

	assign data = data_q;

endmodule

@@ src/pat_front.sv @@
module pat_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pat_pkg::CMD_W-1:0]      cmd,
	input  pat_pkg::coord_t                vec_x,
	input  pat_pkg::coord_t                vec_y,
	input  pat_pkg::coord_t                vec_z,
	input  pat_pkg::coord_t                factor,
	input  logic [pat_pkg::ANGLE_IN_W-1:0] turn_angle,
	output logic                           push_valid,
	input  logic                           push_ready,
	output pat_pkg::item_t                 push_item
);

	logic                       accept;
	pat_pkg::op_t               op;
	pat_pkg::angle_wide_t       angle_wide;
	pat_pkg::angle_t            angle;
	pat_pkg::quarter_idx_t      idx;
	pat_pkg::quarter_idx_t      idx_mirror;
	logic [1:0]                 quad_sin;
	logic [1:0]                 quad_cos;
	pat_pkg::quarter_idx_t      sin_addr;
	pat_pkg::quarter_idx_t      cos_addr;
	logic [pat_pkg::SINE_W-1:0] sin_raw;
	logic [pat_pkg::SINE_W-1:0] cos_raw;

	logic                       valid_s1;
	pat_pkg::op_t               op_s1;
	pat_pkg::coord_t            vec_x_s1;
	pat_pkg::coord_t            vec_y_s1;
	pat_pkg::coord_t            vec_z_s1;
	pat_pkg::coord_t            factor_s1;
	logic                       sin_full_s1;
	logic                       sin_neg_s1;
	logic                       cos_full_s1;
	logic                       cos_neg_s1;

	function automatic pat_pkg::trig_t trig_value(input logic [pat_pkg::SINE_W-1:0] raw,
			input logic full, input logic neg);
		pat_pkg::trig_t mag;
		mag = full ? pat_pkg::trig_t'(pat_pkg::TRIG_ONE) : pat_pkg::trig_t'({1'b0, raw});
		return neg ? -mag : mag;
	endfunction

	assign in_ready = !valid_s1 || push_ready;
	assign accept = in_valid && in_ready;

	always_comb begin
		case (cmd)
			pat_pkg::CMD_LOAD:      op = pat_pkg::OP_LOAD;
			pat_pkg::CMD_TRANSLATE: op = pat_pkg::OP_TRANSLATE;
			pat_pkg::CMD_SCALE:     op = pat_pkg::OP_SCALE;
			pat_pkg::CMD_ROT_X:     op = pat_pkg::OP_ROT_X;
			pat_pkg::CMD_ROT_Y:     op = pat_pkg::OP_ROT_Y;
			pat_pkg::CMD_ROT_Z:     op = pat_pkg::OP_ROT_Z;
			default:                op = pat_pkg::OP_NOP;
		endcase
	end

	// The cosine is the sine a quarter turn on, so both share the in-quadrant
	// index and differ only in the quadrant number.
	always_comb begin
		angle_wide = pat_pkg::angle_wide_t'(turn_angle);
		angle_wide = (angle_wide >> pat_pkg::ANGLE_DROP) << pat_pkg::ANGLE_PAD;
		angle = angle_wide[pat_pkg::ANGLE_BITS-1:0];
		idx = angle[pat_pkg::QUARTER_W-1:0];
		idx_mirror = ~idx + pat_pkg::quarter_idx_t'(1);
		quad_sin = angle[pat_pkg::ANGLE_BITS-1 -: 2];
		quad_cos = quad_sin + 2'd1;
		sin_addr = quad_sin[0] ? idx_mirror : idx;
		cos_addr = quad_cos[0] ? idx_mirror : idx;
	end

	pat_sin_rom u_sin_rom (
		.clk  (clk),
		.en   (accept),
		.addr (sin_addr),
		.data (sin_raw)
	);

	pat_sin_rom u_cos_rom (
		.clk  (clk),
		.en   (accept),
		.addr (cos_addr),
		.data (cos_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			vec_x_s1 <= vec_x;
			vec_y_s1 <= vec_y;
			vec_z_s1 <= vec_z;
			factor_s1 <= factor;
			sin_full_s1 <= quad_sin[0] && (idx == '0);
			sin_neg_s1 <= quad_sin[1];
			cos_full_s1 <= quad_cos[0] && (idx == '0);
			cos_neg_s1 <= quad_cos[1];
		end
	end

	assign push_valid = valid_s1;

	always_comb begin
		push_item.op = op_s1;
		push_item.vec_x = vec_x_s1;
		push_item.vec_y = vec_y_s1;
		push_item.vec_z = vec_z_s1;
		push_item.factor = factor_s1;
		push_item.sin_v = trig_value(sin_raw, sin_full_s1, sin_neg_s1);
		push_item.cos_v = trig_value(cos_raw, cos_full_s1, cos_neg_s1);
	end

endmodule

@@ src/pat_queue.sv @@
module pat_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  pat_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output pat_pkg::item_t pop_item
);

	pat_pkg::item_t                 entry_q [pat_pkg::QUEUE_DEPTH];
	logic [pat_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [pat_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [pat_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                            push;
	logic                            pop;

	function automatic logic [pat_pkg::QUEUE_PTR_W-1:0] next_ptr(
			input logic [pat_pkg::QUEUE_PTR_W-1:0] p);
		if (p == pat_pkg::QUEUE_PTR_W'(pat_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + pat_pkg::QUEUE_PTR_W'(1);
	endfunction

	assign push_ready = (count_q != pat_pkg::QUEUE_CNT_W'(pat_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + pat_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - pat_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ src/pat_back.sv @@
module pat_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  pat_pkg::item_t  pop_item,
	output logic            out_valid,
	input  logic            out_ready,
	output pat_pkg::coord_t out_x,
	output pat_pkg::coord_t out_y,
	output pat_pkg::coord_t out_z,
	output logic            out_saturated
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL_A = 5'b00010,
		ST_MUL_B = 5'b00100,
		ST_FIN_A = 5'b01000,
		ST_FIN_B = 5'b10000
	} state_t;

	state_t             state_q;
	logic               out_valid_q;
	logic               sat_q;
	pat_pkg::coord_t    pos_x_q;
	pat_pkg::coord_t    pos_y_q;
	pat_pkg::coord_t    pos_z_q;

	pat_pkg::item_t     cur_q;
	pat_pkg::diff_t     dx_q;
	pat_pkg::diff_t     dy_q;
	pat_pkg::diff_t     dz_q;
	pat_pkg::prod_t     prod0_q;
	pat_pkg::prod_t     prod1_q;
	pat_pkg::prod_t     sum_q;

	logic               pop;
	logic               multi;
	logic               emit;
	logic               is_scale;
	pat_pkg::sat_res_t  tr_x;
	pat_pkg::sat_res_t  tr_y;
	pat_pkg::sat_res_t  tr_z;
	pat_pkg::diff_t     da;
	pat_pkg::diff_t     db;
	pat_pkg::coord_t    pa;
	pat_pkg::coord_t    pb;
	pat_pkg::diff_t     f_ext;
	pat_pkg::diff_t     c_ext;
	pat_pkg::diff_t     s_ext;
	pat_pkg::diff_t     m0_a;
	pat_pkg::diff_t     m0_b;
	pat_pkg::diff_t     m1_a;
	pat_pkg::diff_t     m1_b;
	pat_pkg::prod_t     m0;
	pat_pkg::prod_t     m1;
	pat_pkg::prod_t     fin0_in;
	pat_pkg::coord_t    fin0_pivot;
	pat_pkg::sat_res_t  fin0;
	pat_pkg::sat_res_t  fin1;

	// A new item is taken only once the previous result has gone or is going,
	// so the result slot is always free when a longer command finishes.
	assign pop_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign pop = pop_valid && pop_ready;
	assign multi = pop_item.op inside {pat_pkg::OP_SCALE, pat_pkg::OP_ROT_X,
		pat_pkg::OP_ROT_Y, pat_pkg::OP_ROT_Z};
	assign is_scale = (cur_q.op == pat_pkg::OP_SCALE);
	assign emit = (pop && !multi) || ((state_q == ST_FIN_A) && is_scale) ||
		(state_q == ST_FIN_B);

	assign tr_x = pat_pkg::sat_add(pos_x_q, pop_item.vec_x);
	assign tr_y = pat_pkg::sat_add(pos_y_q, pop_item.vec_y);
	assign tr_z = pat_pkg::sat_add(pos_z_q, pop_item.vec_z);

	// The rotated pair: a' = a*c + b*s and b' = b*c - a*s about (pa, pb).
	always_comb begin
		da = dx_q;
		db = dy_q;
		pa = cur_q.vec_x;
		pb = cur_q.vec_y;
		case (cur_q.op)
			pat_pkg::OP_ROT_X: begin
				da = dy_q;
				db = dz_q;
				pa = cur_q.vec_y;
				pb = cur_q.vec_z;
			end
			pat_pkg::OP_ROT_Y: begin
				da = dz_q;
				db = dx_q;
				pa = cur_q.vec_z;
				pb = cur_q.vec_x;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		f_ext = pat_pkg::diff_t'(cur_q.factor);
		c_ext = pat_pkg::diff_t'(cur_q.cos_v);
		s_ext = pat_pkg::diff_t'(cur_q.sin_v);
		if (is_scale) begin
			m0_a = (state_q == ST_MUL_B) ? dz_q : dx_q;
			m0_b = f_ext;
			m1_a = dy_q;
			m1_b = f_ext;
		end else if (state_q == ST_MUL_B) begin
			m0_a = db;
			m0_b = c_ext;
			m1_a = da;
			m1_b = s_ext;
		end else begin
			m0_a = da;
			m0_b = c_ext;
			m1_a = db;
			m1_b = s_ext;
		end
		m0 = m0_a * m0_b;
		m1 = m1_a * m1_b;
	end

	always_comb begin
		if (state_q == ST_MUL_B) begin
			fin0_in = prod0_q;
			fin0_pivot = cur_q.vec_x;
		end else if (is_scale) begin
			fin0_in = prod0_q;
			fin0_pivot = cur_q.vec_z;
		end else if (state_q == ST_FIN_A) begin
			fin0_in = sum_q;
			fin0_pivot = pa;
		end else begin
			fin0_in = sum_q;
			fin0_pivot = pb;
		end
		fin0 = pat_pkg::round_sat(fin0_in, fin0_pivot, is_scale);
		fin1 = pat_pkg::round_sat(prod1_q, cur_q.vec_y, is_scale);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			sat_q <= 1'b0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						sat_q <= 1'b0;
						case (pop_item.op)
							pat_pkg::OP_LOAD: begin
								pos_x_q <= pop_item.vec_x;
								pos_y_q <= pop_item.vec_y;
								pos_z_q <= pop_item.vec_z;
							end
							pat_pkg::OP_TRANSLATE: begin
								pos_x_q <= tr_x.value;
								pos_y_q <= tr_y.value;
								pos_z_q <= tr_z.value;
								sat_q <= tr_x.clip | tr_y.clip | tr_z.clip;
							end
							pat_pkg::OP_SCALE, pat_pkg::OP_ROT_X, pat_pkg::OP_ROT_Y,
									pat_pkg::OP_ROT_Z: begin
								state_q <= ST_MUL_A;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL_A: begin
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					if (is_scale) begin
						pos_x_q <= fin0.value;
						pos_y_q <= fin1.value;
						sat_q <= sat_q | fin0.clip | fin1.clip;
					end
					state_q <= ST_FIN_A;
				end
				ST_FIN_A: begin
					sat_q <= sat_q | fin0.clip;
					case (cur_q.op)
						pat_pkg::OP_SCALE: pos_z_q <= fin0.value;
						pat_pkg::OP_ROT_X: pos_y_q <= fin0.value;
						pat_pkg::OP_ROT_Y: pos_z_q <= fin0.value;
						default:           pos_x_q <= fin0.value;
					endcase
					state_q <= is_scale ? ST_IDLE : ST_FIN_B;
				end
				ST_FIN_B: begin
					sat_q <= sat_q | fin0.clip;
					case (cur_q.op)
						pat_pkg::OP_ROT_X: pos_z_q <= fin0.value;
						pat_pkg::OP_ROT_Y: pos_x_q <= fin0.value;
						default:           pos_y_q <= fin0.value;
					endcase
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_item;
			dx_q <= pat_pkg::diff_t'(pos_x_q) - pat_pkg::diff_t'(pop_item.vec_x);
			dy_q <= pat_pkg::diff_t'(pos_y_q) - pat_pkg::diff_t'(pop_item.vec_y);
			dz_q <= pat_pkg::diff_t'(pos_z_q) - pat_pkg::diff_t'(pop_item.vec_z);
		end
		if ((state_q == ST_MUL_A) || (state_q == ST_MUL_B)) begin
			prod0_q <= m0;
			prod1_q <= m1;
		end
		if (state_q == ST_MUL_B) begin
			sum_q <= prod0_q + prod1_q;
		end else if (state_q == ST_FIN_A) begin
			sum_q <= prod0_q - prod1_q;
		end
	end

	// The held point doubles as the result register: it changes only while
	// the result slot is empty or its result is being taken.
	assign out_valid = out_valid_q;
	assign out_x = pos_x_q;
	assign out_y = pos_y_q;
	assign out_z = pos_z_q;
	assign out_saturated = sat_q;

endmodule

@@ src/point_affine_transform_3d.sv @@
// Holds one 3D point in signed Q16.16 and applies one command per input item:
// load, translate, scale about a pivot, or rotate about a pivot around X, Y or Z.
// Every item gives exactly one result item carrying the point after the command.
// Input channel s_*: tuser is the command code, tdata the operand vector,
// factor and angle. Output channel m_*: tdata is the point, tuser the clip flag.
// Items are accepted into a one-stage front end that looks up sine and cosine in
// two quarter-wave tables, then into a two-entry queue, so input keeps flowing
// while the receiver stalls until three items are held.
// Load, translate and unused codes update the point as the sequencer takes them;
// scale and rotations step through its multiply and finish states in turn.
// Throughput: one item per cycle for load and translate while results are taken;
// scale and rotations hold off the next item until the execute sequencer, with
// its two shared 33 x 33 multipliers, is idle; each needs the previous point.
// A result is held on m_* until taken; while it waits no further command runs.
// Reset clears the point to zero and empties the front stage, queue and result.
module point_affine_transform_3d (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// vec_x, vec_y, vec_z, factor, turn_angle
	input  logic [pat_pkg::IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic [pat_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_x, out_y, out_z
	output logic [pat_pkg::OUT_TDATA_W-1:0] m_tdata,
	// saturated
	output logic                            m_tuser
);

	localparam int CW = pat_pkg::COORD_W;

	logic            push_valid;
	logic            push_ready;
	pat_pkg::item_t  push_item;
	logic            pop_valid;
	logic            pop_ready;
	pat_pkg::item_t  pop_item;
	pat_pkg::coord_t out_x;
	pat_pkg::coord_t out_y;
	pat_pkg::coord_t out_z;

	pat_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.cmd        (s_tuser),
		.vec_x      (s_tdata[CW-1:0]),
		.vec_y      (s_tdata[2*CW-1:CW]),
		.vec_z      (s_tdata[3*CW-1:2*CW]),
		.factor     (s_tdata[4*CW-1:3*CW]),
		.turn_angle (s_tdata[4*CW+pat_pkg::ANGLE_IN_W-1:4*CW]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	pat_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	pat_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_item      (pop_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_saturated (m_tuser)
	);

	assign m_tdata = pat_pkg::OUT_TDATA_W'({out_z, out_y, out_x});

endmodule
